[rtl/lni_pkg.sv]
// Package for the lattice neighbour index core: field widths, register
// indexes, lattice form codes and the restoring divider step.
// Depends on nothing; used by lattice_neighbour_index_core.
package lni_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int SITE_W      = 13;
   localparam int SIDE_W      = 7;
   localparam int AREA_W      = 2 * SIDE_W;
   localparam int REM_W       = SIDE_W;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   // Lowest quotient bit of the first and second divider stages; bits run most significant first.
   localparam int DIV_B_LO = 9;
   localparam int DIV_C_LO = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE    = 2'd0,
      CSR_COLUMNS = 2'd1,
      CSR_ROWS    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_HEX_OPEN     = 3'd0,
      MODE_HEX_PERIODIC = 3'd1,
      MODE_HEX_REV      = 3'd2,
      MODE_HEX_REV_TWO  = 3'd3,
      MODE_TRI_OPEN     = 3'd4,
      MODE_TRI_PERIODIC = 3'd5
   } lattice_mode_type;

   localparam logic [2:0]        MODE_RESET    = MODE_HEX_OPEN;
   localparam logic [SIDE_W-1:0] COLUMNS_RESET = SIDE_W'(4);
   localparam logic [SIDE_W-1:0] ROWS_RESET    = SIDE_W'(4);

   // One restoring division step: returns the quotient bit above the new
   // remainder.
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic dbit,
                                                input logic [SIDE_W-1:0] divisor);
      logic [REM_W:0] trial;
      logic [REM_W:0] result;
      trial = {rem, dbit};
      if (trial >= {1'b0, divisor}) begin
         result = {1'b1, REM_W'(trial - {1'b0, divisor})};
      end else begin
         result = {1'b0, trial[REM_W-1:0]};
      end
      return result;
   endfunction

endpackage

[rtl/lattice_neighbour_index_core.sv]
// Lattice neighbour index core: site number in, three neighbour site numbers
// and a range error flag out, through a five-stage pipeline.
// Depends on lni_pkg.
//
//   Channel | Direction | Words              | Handshake
//   csr_    | in        | mode, columns, rows | csr_we, no back-pressure
//   req_    | in        | site                | req_tvalid / req_tready
//   rsp_    | out       | neighbours, error   | rsp_tvalid / rsp_tready
//
// One word enters per cycle while no stall on the result side holds it back.
// Stage one registers the word with the current configuration, the next
// three stages share the 13 quotient bits of the column/row split and compute
// the candidate sums, the last stage selects them into the output register.
// Reset (synchronous) restores the configuration registers and empties the
// pipeline. Each stage loads when it is empty or the stage after it moves, so
// a stall on the result side holds every word in place.
module lattice_neighbour_index_core
   import lni_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [SIDE_W-1:0]      csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // site [12:0], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // first, second, third neighbour
   output logic [0:0]             rsp_tuser    // site_error
);

   typedef struct packed {
      logic [SITE_W-1:0] p_plus1;
      logic [SITE_W-1:0] p_minus1;
      logic [SITE_W-1:0] p_less_ly_plus1;
      logic [SITE_W-1:0] p_plus_ly_minus1;
      logic [SITE_W-1:0] p_plus_ly_plus1;
      logic [SITE_W-1:0] p_plus_ly;
      logic [SITE_W-1:0] p_plus_2ly_minus1;
      logic [SITE_W-1:0] wrap_up_plus1;
      logic [SITE_W-1:0] wrap_dn_plus1;
      logic [SITE_W-1:0] wrap_dn;
      logic [SITE_W-1:0] wrap_dn_minus1;
      logic [SITE_W-1:0] wrap2_dn_minus1;
      logic              is_first;
      logic              is_last;
   } cand_type;

   typedef struct packed {
      logic [SITE_W-1:0] p;
      logic [2:0]        mode;
      logic [SIDE_W-1:0] lx;
      logic [SIDE_W-1:0] ly;
   } stage_a_type;

   typedef struct packed {
      logic [SITE_W-1:0] p;
      logic [2:0]        mode;
      logic [SIDE_W-1:0] lx;
      logic [SIDE_W-1:0] ly;
      logic [AREA_W-1:0] area;
      logic              size_ok;
      logic [SITE_W-1:0] dvd;
      logic [SITE_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } stage_b_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [SIDE_W-1:0] lx;
      logic [SIDE_W-1:0] ly;
      logic              err;
      logic [SITE_W-1:0] dvd;
      logic [SITE_W-1:0] quot;
      logic [REM_W-1:0]  rem;
      cand_type          cand;
   } stage_c_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [SIDE_W-1:0] lx;
      logic [SIDE_W-1:0] ly;
      logic              err;
      logic [SITE_W-1:0] x;
      logic [REM_W-1:0]  y;
      cand_type          cand;
   } stage_d_type;

   typedef struct packed {
      logic [SITE_W-1:0] n0;
      logic [SITE_W-1:0] n1;
      logic [SITE_W-1:0] n2;
      logic              err;
   } stage_e_type;

   logic [2:0]        mode_ff;
   logic [SIDE_W-1:0] columns_ff;
   logic [SIDE_W-1:0] rows_ff;

   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   stage_c_type c_ff, c_in;
   stage_d_type d_ff, d_in;
   stage_e_type e_ff, e_in;

   assign e_rdy = !e_vld_ff || rsp_tready;
   assign d_rdy = !d_vld_ff || e_rdy;
   assign c_rdy = !c_vld_ff || d_rdy;
   assign b_rdy = !b_vld_ff || c_rdy;
   assign a_rdy = !a_vld_ff || b_rdy;

   assign req_tready = a_rdy;
   assign rsp_tvalid = e_vld_ff;
   assign rsp_tdata  = {1'b0, e_ff.n2, e_ff.n1, e_ff.n0};
   assign rsp_tuser  = e_ff.err;

   always_comb begin
      a_in.p    = req_tdata[SITE_W-1:0];
      a_in.mode = mode_ff;
      a_in.lx   = columns_ff;
      a_in.ly   = rows_ff;
   end

   always_comb begin
      logic [REM_W:0]    step;
      logic [REM_W-1:0]  rem;
      logic [SITE_W-1:0] quot;
      logic [SITE_W-1:0] dvd;
      dvd  = a_ff.p - SITE_W'(1);
      rem  = '0;
      quot = '0;
      for (int i = SITE_W - 1; i >= DIV_B_LO; i--) begin
         step    = div_step(rem, dvd[i], a_ff.ly);
         quot[i] = step[REM_W];
         rem     = step[REM_W-1:0];
      end
      b_in.p       = a_ff.p;
      b_in.mode    = a_ff.mode;
      b_in.lx      = a_ff.lx;
      b_in.ly      = a_ff.ly;
      b_in.area    = AREA_W'(a_ff.lx) * AREA_W'(a_ff.ly);
      b_in.size_ok = (a_ff.lx != '0) && (a_ff.lx <= SIDE_W'(MAX_SIDE)) &&
                     (a_ff.ly != '0) && (a_ff.ly <= SIDE_W'(MAX_SIDE));
      b_in.dvd     = dvd;
      b_in.quot    = quot;
      b_in.rem     = rem;
   end

   always_comb begin
      logic [REM_W:0]    step;
      logic [REM_W-1:0]  rem;
      logic [SITE_W-1:0] quot;
      logic [SITE_W-1:0] p;
      logic [SITE_W-1:0] ly;
      logic [SITE_W-1:0] area;
      rem  = b_ff.rem;
      quot = b_ff.quot;
      for (int i = DIV_B_LO - 1; i >= DIV_C_LO; i--) begin
         step    = div_step(rem, b_ff.dvd[i], b_ff.ly);
         quot[i] = step[REM_W];
         rem     = step[REM_W-1:0];
      end
      p    = b_ff.p;
      ly   = SITE_W'(b_ff.ly);
      area = b_ff.area[SITE_W-1:0];
      c_in.mode = b_ff.mode;
      c_in.lx   = b_ff.lx;
      c_in.ly   = b_ff.ly;
      c_in.err  = !b_ff.size_ok || (p == '0) || ({1'b0, p} > b_ff.area);
      c_in.dvd  = b_ff.dvd;
      c_in.quot = quot;
      c_in.rem  = rem;
      // Sums of the column span wrap modulo the field width, as the results do.
      c_in.cand.p_plus1           = p + SITE_W'(1);
      c_in.cand.p_minus1          = p - SITE_W'(1);
      c_in.cand.p_less_ly_plus1   = p - ly + SITE_W'(1);
      c_in.cand.p_plus_ly_minus1  = p + ly - SITE_W'(1);
      c_in.cand.p_plus_ly_plus1   = p + ly + SITE_W'(1);
      c_in.cand.p_plus_ly         = p + ly;
      c_in.cand.p_plus_2ly_minus1 = p + (ly << 1) - SITE_W'(1);
      c_in.cand.wrap_up_plus1     = p + area - ly + SITE_W'(1);
      c_in.cand.wrap_dn_plus1     = p - area + ly + SITE_W'(1);
      c_in.cand.wrap_dn           = p - area + ly;
      c_in.cand.wrap_dn_minus1    = p - area + ly - SITE_W'(1);
      c_in.cand.wrap2_dn_minus1   = p - area + (ly << 1) - SITE_W'(1);
      c_in.cand.is_first          = (p == SITE_W'(1));
      c_in.cand.is_last           = (p == area);
   end

   always_comb begin
      logic [REM_W:0]    step;
      logic [REM_W-1:0]  rem;
      logic [SITE_W-1:0] quot;
      rem  = c_ff.rem;
      quot = c_ff.quot;
      for (int i = DIV_C_LO - 1; i >= 0; i--) begin
         step    = div_step(rem, c_ff.dvd[i], c_ff.ly);
         quot[i] = step[REM_W];
         rem     = step[REM_W-1:0];
      end
      d_in.mode = c_ff.mode;
      d_in.lx   = c_ff.lx;
      d_in.ly   = c_ff.ly;
      d_in.err  = c_ff.err;
      d_in.x    = quot;
      d_in.y    = rem;
      d_in.cand = c_ff.cand;
   end

   always_comb begin
      logic     x_first;
      logic     x_last;
      logic     y_first;
      logic     y_last;
      cand_type c;
      c       = d_ff.cand;
      x_first = (d_ff.x == '0);
      x_last  = (d_ff.x == SITE_W'(d_ff.lx) - SITE_W'(1));
      y_first = (d_ff.y == '0);
      y_last  = (d_ff.y == d_ff.ly - SIDE_W'(1));
      e_in.n0  = '0;
      e_in.n1  = '0;
      e_in.n2  = '0;
      e_in.err = d_ff.err;
      if (!d_ff.err) begin
         case (d_ff.mode)
            MODE_HEX_OPEN: begin
               e_in.n0 = y_last ? '0 : c.p_plus1;
               e_in.n1 = x_first ? '0 : c.p_less_ly_plus1;
               e_in.n2 = (c.is_first || c.is_last) ? '0 : c.p_minus1;
            end
            MODE_HEX_PERIODIC: begin
               e_in.n0 = y_last ? '0 : c.p_plus1;
               e_in.n1 = x_first ? c.wrap_up_plus1 : c.p_less_ly_plus1;
               e_in.n2 = y_first ? c.p_plus_ly_minus1 : c.p_minus1;
            end
            MODE_HEX_REV: begin
               e_in.n0 = x_last ? c.wrap_dn_plus1 : c.p_plus_ly_plus1;
               e_in.n1 = c.p_plus1;
               e_in.n2 = y_first ? c.p_plus_ly_minus1 : c.p_minus1;
            end
            MODE_HEX_REV_TWO: begin
               e_in.n0 = x_first ? c.wrap_up_plus1 : c.p_less_ly_plus1;
               e_in.n1 = c.p_plus1;
               e_in.n2 = y_first ? c.p_plus_ly_minus1 : c.p_minus1;
            end
            MODE_TRI_OPEN: begin
               e_in.n0 = x_last ? '0 : c.p_plus_ly;
               e_in.n1 = (y_last && x_last) ? '0 : c.p_plus1;
               e_in.n2 = (x_last || y_first) ? '0 : c.p_plus_ly_minus1;
            end
            MODE_TRI_PERIODIC: begin
               if (!x_last) begin
                  e_in.n0 = c.p_plus_ly;
                  e_in.n2 = y_first ? c.p_plus_2ly_minus1 : c.p_plus_ly_minus1;
               end else begin
                  e_in.n0 = c.wrap_dn;
                  e_in.n2 = y_first ? c.wrap2_dn_minus1 : c.wrap_dn_minus1;
               end
               e_in.n1 = y_last ? c.p_less_ly_plus1 : c.p_plus1;
            end
            default: begin
               e_in.n0 = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         e_vld_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:    mode_ff    <= csr_wdata[2:0];
               CSR_COLUMNS: columns_ff <= csr_wdata;
               CSR_ROWS:    rows_ff    <= csr_wdata;
               default:     mode_ff    <= mode_ff;
            endcase
         end
         if (a_rdy) a_vld_ff <= req_tvalid;
         if (b_rdy) b_vld_ff <= a_vld_ff;
         if (c_rdy) c_vld_ff <= b_vld_ff;
         if (d_rdy) d_vld_ff <= c_vld_ff;
         if (e_rdy) e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy) a_ff <= a_in;
      if (b_rdy) b_ff <= b_in;
      if (c_rdy) c_ff <= c_in;
      if (d_rdy) d_ff <= d_in;
      if (e_rdy) e_ff <= e_in;
   end

endmodule

[sim/lattice_neighbour_index_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lattice_neighbour_index_core: a scoreboard class
// predicts the neighbour triple of every accepted site word and checks results.
// Depends on lni_pkg and the lattice_neighbour_index_core RTL.
module lattice_neighbour_index_core_tb;
   import lni_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;
   localparam logic [2:0]           MODE_UNUSED_A = 3'd6;
   localparam logic [2:0]           MODE_UNUSED_B = 3'd7;
   localparam int                   MAX_GAP       = 14;
   localparam int                   SITE_MAX      = (1 << SITE_W) - 1;

   typedef struct {
      logic [SITE_W-1:0] site;
      logic [SITE_W-1:0] first;
      logic [SITE_W-1:0] second;
      logic [SITE_W-1:0] third;
      logic              err;
   } neighbour_set_type;

   class neighbour_scoreboard;
      logic [2:0]        mode;
      logic [SIDE_W-1:0] columns;
      logic [SIDE_W-1:0] rows;
      neighbour_set_type pending_sets[$];
      int                errors;

      function new();
         mode    = MODE_RESET;
         columns = COLUMNS_RESET;
         rows    = ROWS_RESET;
         errors  = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [SIDE_W-1:0] data);
         case (idx)
            CSR_MODE:    mode    = data[2:0];
            CSR_COLUMNS: columns = data;
            CSR_ROWS:    rows    = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_sets.size();
      endfunction

      function neighbour_set_type predict(logic [SITE_W-1:0] site);
         int p, lx, ly, x, y, yr, n0, n1, n2;
         neighbour_set_type r;
         p  = site;
         lx = columns;
         ly = rows;
         n0 = 0;
         n1 = 0;
         n2 = 0;
         r.site = site;
         r.err  = 1'b0;
         if (lx < 1 || lx > MAX_SIDE || ly < 1 || ly > MAX_SIDE || p < 1 || p > lx * ly) begin
            r.err = 1'b1;
         end else begin
            x  = (p - 1) / ly;
            y  = (p - 1) % ly;
            yr = ly - 1 - y;
            case (mode)
               MODE_HEX_OPEN: begin
                  if (y != ly - 1) n0 = p + 1;
                  if (x != 0) n1 = p - ly + 1;
                  if (p != 1 && p != lx * ly) n2 = p - 1;
               end
               MODE_HEX_PERIODIC: begin
                  if (y != ly - 1) n0 = p + 1;
                  n1 = (x != 0) ? p - ly + 1 : p + (lx - 1) * ly + 1;
                  n2 = (y != 0) ? p - 1 : p + ly - 1;
               end
               MODE_HEX_REV: begin
                  n0 = (x != lx - 1) ? p + ly + 1 : p - (lx - 1) * ly + 1;
                  n1 = p + 1;
                  n2 = (y != 0) ? p - 1 : p + ly - 1;
               end
               MODE_HEX_REV_TWO: begin
                  n0 = (x != 0) ? p - ly + 1 : p + (lx - 1) * ly + 1;
                  n1 = p + 1;
                  n2 = (yr != ly - 1) ? p - 1 : p + ly - 1;
               end
               MODE_TRI_OPEN: begin
                  if (x != lx - 1) begin
                     n0 = p + ly;
                     if (y != 0) n2 = p + ly - 1;
                  end
                  if (y != ly - 1 || x != lx - 1) n1 = p + 1;
               end
               MODE_TRI_PERIODIC: begin
                  if (x != lx - 1) begin
                     n0 = p + ly;
                     n2 = (y == 0) ? p + 2 * ly - 1 : p + ly - 1;
                  end else begin
                     n0 = p - (lx - 1) * ly;
                     n2 = (y == 0) ? p - (lx - 2) * ly - 1 : p - (lx - 1) * ly - 1;
                  end
                  n1 = (y == ly - 1) ? p + 1 - ly : p + 1;
               end
               default: ;
            endcase
         end
         r.first  = SITE_W'(n0);
         r.second = SITE_W'(n1);
         r.third  = SITE_W'(n2);
         return r;
      endfunction

      function void note_site(logic [SITE_W-1:0] site);
         pending_sets.insert(pending_sets.size(), predict(site));
      endfunction

      function void compare_field(string name, logic [SITE_W-1:0] site,
                                  logic [SITE_W-1:0] exp_val, logic [SITE_W-1:0] act_val);
         if (exp_val !== act_val) begin
            errors++;
            $display("%0t: site %0d %s mismatch, expected %0d, actual %0d",
                     $time, site, name, exp_val, act_val);
         end
      endfunction

      function void check_word(logic [RSP_TDATA_W-1:0] data, logic [0:0] user);
         neighbour_set_type e;
         if (pending_sets.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual %h / %b",
                     $time, data, user);
         end else begin
            e = pending_sets.pop_front();
            compare_field("first_neighbour", e.site, e.first, data[SITE_W-1:0]);
            compare_field("second_neighbour", e.site, e.second, data[2*SITE_W-1:SITE_W]);
            compare_field("third_neighbour", e.site, e.third, data[3*SITE_W-1:2*SITE_W]);
            compare_field("site_error", e.site, SITE_W'(e.err), SITE_W'(user[0]));
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_MODE;
   logic [SIDE_W-1:0]      csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;

   neighbour_scoreboard sb = new();
   logic [SITE_W-1:0]   site_batch[$];
   bit                  req_no_idle = 1'b0;
   bit                  rsp_no_idle = 1'b0;

   lattice_neighbour_index_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap(bit no_idle);
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [SIDE_W-1:0] pick_side();
      int k;
      k = $urandom_range(0, 19);
      if (k < 2) return SIDE_W'(1);
      if (k < 4) return SIDE_W'(MAX_SIDE);
      if (k == 4) return ($urandom_range(0, 1) == 0) ? SIDE_W'(0)
                                                     : SIDE_W'($urandom_range(MAX_SIDE + 1, 127));
      return SIDE_W'($urandom_range(1, MAX_SIDE));
   endfunction

   function automatic logic [2:0] pick_mode();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) == 0) ? MODE_UNUSED_A
                                                                         : MODE_UNUSED_B;
      return 3'($urandom_range(MODE_HEX_OPEN, MODE_TRI_PERIODIC));
   endfunction

   function automatic logic [SITE_W-1:0] pick_site();
      int lx, ly, area;
      lx   = sb.columns;
      ly   = sb.rows;
      area = (lx >= 1 && lx <= MAX_SIDE && ly >= 1 && ly <= MAX_SIDE) ? lx * ly : 0;
      case ($urandom_range(0, 19))
         0: return '0;
         1: return SITE_W'(area);
         2: return SITE_W'(area + 1);
         3: return SITE_W'($urandom_range(0, SITE_MAX));
         4: return SITE_W'(1);
         default: return (area > 0) ? SITE_W'($urandom_range(1, area))
                                    : SITE_W'($urandom_range(0, SITE_MAX));
      endcase
   endfunction

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIDE_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic configure(input logic [2:0] mode, input logic [SIDE_W-1:0] cols,
                            input logic [SIDE_W-1:0] rws);
      wait_drained();
      write_reg(CSR_MODE, {4'($urandom_range(0, 15)), mode});
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS, rws);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, SIDE_W'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drive_batch();
      int gap;
      while (site_batch.size() != 0) begin
         gap = draw_gap(req_no_idle);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= REQ_TDATA_W'(site_batch[0]);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.note_site(site_batch.pop_front());
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int gap;
      wait (!reset);
      forever begin
         gap = draw_gap(rsp_no_idle);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_word(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset configuration is used as it stands first.
      site_batch = '{0, 1, 16, 17};
      drive_batch();
      for (int k = MODE_HEX_OPEN; k <= MODE_TRI_PERIODIC; k++) begin
         configure(3'(k), SIDE_W'(3), SIDE_W'(5));
         site_batch = '{1, 15};
         drive_batch();
      end
      configure(MODE_UNUSED_A, SIDE_W'(3), SIDE_W'(5));
      site_batch = '{7};
      drive_batch();
      configure(MODE_UNUSED_B, SIDE_W'(3), SIDE_W'(5));
      site_batch = '{16};
      drive_batch();
      configure(MODE_TRI_PERIODIC, SIDE_W'(MAX_SIDE), SIDE_W'(MAX_SIDE));
      site_batch = '{4096, 4097, SITE_MAX};
      drive_batch();
      configure(MODE_HEX_OPEN, SIDE_W'(0), SIDE_W'(5));
      site_batch = '{1};
      drive_batch();

      for (int ph = 0; ph < 31; ph++) begin
         configure(pick_mode(), pick_side(), pick_side());
         req_no_idle = ($urandom_range(0, 3) == 0);
         rsp_no_idle = ($urandom_range(0, 3) == 0);
         count = $urandom_range(40, 80);
         repeat (count) site_batch.insert(site_batch.size(), pick_site());
         drive_batch();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/lni_pkg.sv
rtl/lattice_neighbour_index_core.sv
sim/lattice_neighbour_index_core_tb.sv
